@@ design/fsat_pkg.sv @@
// Package for the flash sector allocation tracker.
// Holds the word types, codes, controller/datapath signal groups and defaults.
// No dependencies.
package fsat_pkg;

    localparam int SECTOR_BYTES_DEF   = 4096;
    localparam int HEADER_SECTORS_DEF = 3;
    localparam int CACHE_ENTRIES_DEF  = 8;
    localparam int ADDRESS_BITS_DEF   = 26;

    localparam logic [31:0] SIGNATURE_WORD  = 32'hc0ffeea5;
    localparam logic [31:0] SIGNATURE_BYTES = 32'd4;
    localparam logic [7:0]  FLAG_BIT        = 8'h01;
    localparam int          FLAG_BYTE_SHIFT = 3;

    typedef enum logic [1:0] {
        FUNC_WRITE  = 2'd0,
        FUNC_READ   = 2'd1,
        FUNC_FLAG   = 2'd2,
        FUNC_FORMAT = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        CMD_READ_FLAG  = 3'd0,
        CMD_ERASE      = 3'd1,
        CMD_WRITE_FLAG = 3'd2,
        CMD_WRITE_DATA = 3'd3,
        CMD_READ_DATA  = 3'd4,
        CMD_REFUSED    = 3'd5,
        CMD_SIGNATURE  = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WRITE,
        PH_READ_FIRST,
        PH_READ_LAST
    } t_phase;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WLOOK,
        S_WCHECK,
        S_RLOOK,
        S_RCHECK,
        S_ELOOK,
        S_ECHECK,
        S_WREPLY,
        S_FLAGW,
        S_WDATA,
        S_RFREPLY,
        S_RLREPLY,
        S_FMT,
        S_SIG
    } t_state;

    typedef enum logic [2:0] {
        A_SAVED,
        A_FLAG,
        A_SECTOR,
        A_HEADER,
        A_ZERO
    } t_addr_sel;

    typedef struct packed {
        logic [1:0]  func;
        logic [24:0] stream_address;
        logic [15:0] byte_count;
        logic [7:0]  flag_byte;
    } t_in;

    typedef struct packed {
        t_cmd        command;
        logic [25:0] flash_address;
        logic [15:0] data_length;
        logic [31:0] write_value;
        logic        last;
    } t_out;

    typedef struct packed {
        logic      load_item;
        logic      load_req;
        logic      key_end;
        logic      cache_add;
        logic      cache_clear;
        logic      cnt_clr;
        logic      cnt_inc;
        logic      emit;
        t_cmd      cmd;
        t_addr_sel addr_sel;
        logic      last;
    } t_ctl;

    typedef struct packed {
        logic hit;
        logic flag_set;
        logic cnt_done;
    } t_sts;

endpackage

@@ design/flash_sector_allocation_tracker.sv @@
// Flash sector allocation tracker, one word at a time. busy falls with the last result
// on the ports, so the next word can be accepted while that result is on the ports.
// Each cache lookup takes a look state and then a check state on the registered hit vector.
// Synchronous active-low reset clears cache, ring pointer and phase; receiver cannot stall.
module flash_sector_allocation_tracker #(
    parameter int SECTOR_BYTES   = fsat_pkg::SECTOR_BYTES_DEF,
    parameter int HEADER_SECTORS = fsat_pkg::HEADER_SECTORS_DEF,
    parameter int CACHE_ENTRIES  = fsat_pkg::CACHE_ENTRIES_DEF,
    parameter int ADDRESS_BITS   = fsat_pkg::ADDRESS_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  fsat_pkg::t_in  i_in,
    output logic           o_valid,
    output fsat_pkg::t_out o_out
);

    fsat_pkg::t_ctl w_ctl;
    fsat_pkg::t_sts w_sts;

    fsat_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (i_in.func),
        .i_sts   (w_sts),
        .o_busy  (busy),
        .o_ctl   (w_ctl)
    );

    fsat_dp #(
        .SECTOR_BYTES   (SECTOR_BYTES),
        .HEADER_SECTORS (HEADER_SECTORS),
        .CACHE_ENTRIES  (CACHE_ENTRIES),
        .ADDRESS_BITS   (ADDRESS_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_ctl   (w_ctl),
        .o_sts   (w_sts),
        .o_valid (o_valid),
        .o_out   (o_out)
    );

endmodule

@@ design/fsat_ctrl.sv @@
// Controller of the flash sector allocation tracker: sequencer state machine,
// pending request phase and first-byte check flag. Depends on fsat_pkg.
module fsat_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [1:0]      i_func,
    input  fsat_pkg::t_sts  i_sts,
    output logic            o_busy,
    output fsat_pkg::t_ctl  o_ctl
);

    fsat_pkg::t_state r_state, n_state;
    fsat_pkg::t_phase r_phase, n_phase;
    logic             r_first_ok, n_first_ok;
    logic             w_accept;
    fsat_pkg::t_func  w_func;

    assign o_busy   = (r_state != fsat_pkg::S_IDLE);
    assign w_accept = i_start && !o_busy;
    assign w_func   = fsat_pkg::t_func'(i_func);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= fsat_pkg::S_IDLE;
            r_phase    <= fsat_pkg::PH_IDLE;
            r_first_ok <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_first_ok <= n_first_ok;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fsat_pkg::S_IDLE: begin
                if (w_accept) begin
                    unique case (w_func)
                        fsat_pkg::FUNC_WRITE:  n_state = fsat_pkg::S_WLOOK;
                        fsat_pkg::FUNC_READ:   n_state = fsat_pkg::S_RLOOK;
                        fsat_pkg::FUNC_FORMAT: n_state = fsat_pkg::S_FMT;
                        fsat_pkg::FUNC_FLAG: begin
                            unique case (r_phase)
                                fsat_pkg::PH_WRITE:      n_state = fsat_pkg::S_WREPLY;
                                fsat_pkg::PH_READ_FIRST: n_state = fsat_pkg::S_RFREPLY;
                                fsat_pkg::PH_READ_LAST:  n_state = fsat_pkg::S_RLREPLY;
                                fsat_pkg::PH_IDLE:       n_state = fsat_pkg::S_IDLE;
                            endcase
                        end
                    endcase
                end
            end
            fsat_pkg::S_WLOOK:   n_state = fsat_pkg::S_WCHECK;
            fsat_pkg::S_WCHECK:  n_state = fsat_pkg::S_IDLE;
            fsat_pkg::S_RLOOK:   n_state = fsat_pkg::S_RCHECK;
            fsat_pkg::S_RCHECK:  n_state = i_sts.hit ? fsat_pkg::S_ELOOK : fsat_pkg::S_IDLE;
            fsat_pkg::S_ELOOK:   n_state = fsat_pkg::S_ECHECK;
            fsat_pkg::S_ECHECK:  n_state = fsat_pkg::S_IDLE;
            fsat_pkg::S_WREPLY:  n_state = i_sts.flag_set ? fsat_pkg::S_FLAGW : fsat_pkg::S_WDATA;
            fsat_pkg::S_FLAGW:   n_state = fsat_pkg::S_WDATA;
            fsat_pkg::S_WDATA:   n_state = fsat_pkg::S_IDLE;
            fsat_pkg::S_RFREPLY: n_state = fsat_pkg::S_ELOOK;
            fsat_pkg::S_RLREPLY: n_state = fsat_pkg::S_IDLE;
            fsat_pkg::S_FMT:     n_state = i_sts.cnt_done ? fsat_pkg::S_SIG : fsat_pkg::S_FMT;
            fsat_pkg::S_SIG:     n_state = fsat_pkg::S_IDLE;
            default:             n_state = fsat_pkg::S_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_ctl           = '0;
        o_ctl.cmd       = fsat_pkg::CMD_READ_FLAG;
        o_ctl.addr_sel  = fsat_pkg::A_ZERO;
        unique case (r_state)
            fsat_pkg::S_IDLE: begin
                o_ctl.load_item = w_accept;
                o_ctl.load_req  = w_accept && (w_func == fsat_pkg::FUNC_WRITE ||
                                               w_func == fsat_pkg::FUNC_READ);
                o_ctl.cnt_clr   = w_accept;
            end
            fsat_pkg::S_WLOOK, fsat_pkg::S_RLOOK: begin
                o_ctl.key_end = 1'b0;
            end
            fsat_pkg::S_WCHECK: begin
                o_ctl.emit     = 1'b1;
                o_ctl.last     = 1'b1;
                o_ctl.cmd      = i_sts.hit ? fsat_pkg::CMD_WRITE_DATA : fsat_pkg::CMD_READ_FLAG;
                o_ctl.addr_sel = i_sts.hit ? fsat_pkg::A_SAVED : fsat_pkg::A_FLAG;
            end
            fsat_pkg::S_RCHECK: begin
                o_ctl.emit     = !i_sts.hit;
                o_ctl.last     = 1'b1;
                o_ctl.cmd      = fsat_pkg::CMD_READ_FLAG;
                o_ctl.addr_sel = fsat_pkg::A_FLAG;
            end
            fsat_pkg::S_ELOOK: begin
                o_ctl.key_end = 1'b1;
            end
            fsat_pkg::S_ECHECK: begin
                o_ctl.key_end = 1'b1;
                o_ctl.emit    = 1'b1;
                o_ctl.last    = 1'b1;
                if (i_sts.hit) begin
                    o_ctl.cmd      = r_first_ok ? fsat_pkg::CMD_READ_DATA
                                                : fsat_pkg::CMD_REFUSED;
                    o_ctl.addr_sel = fsat_pkg::A_SAVED;
                end else begin
                    o_ctl.cmd      = fsat_pkg::CMD_READ_FLAG;
                    o_ctl.addr_sel = fsat_pkg::A_FLAG;
                end
            end
            fsat_pkg::S_WREPLY: begin
                o_ctl.emit     = i_sts.flag_set;
                o_ctl.cmd      = fsat_pkg::CMD_ERASE;
                o_ctl.addr_sel = fsat_pkg::A_SECTOR;
            end
            fsat_pkg::S_FLAGW: begin
                o_ctl.emit     = 1'b1;
                o_ctl.cmd      = fsat_pkg::CMD_WRITE_FLAG;
                o_ctl.addr_sel = fsat_pkg::A_FLAG;
            end
            fsat_pkg::S_WDATA: begin
                o_ctl.cache_add = 1'b1;
                o_ctl.emit      = 1'b1;
                o_ctl.last      = 1'b1;
                o_ctl.cmd       = fsat_pkg::CMD_WRITE_DATA;
                o_ctl.addr_sel  = fsat_pkg::A_SAVED;
            end
            fsat_pkg::S_RFREPLY: begin
                o_ctl.cache_add = !i_sts.flag_set;
            end
            fsat_pkg::S_RLREPLY: begin
                o_ctl.key_end   = 1'b1;
                o_ctl.cache_add = !i_sts.flag_set;
                o_ctl.emit      = 1'b1;
                o_ctl.last      = 1'b1;
                o_ctl.cmd       = (!i_sts.flag_set && r_first_ok) ? fsat_pkg::CMD_READ_DATA
                                                                  : fsat_pkg::CMD_REFUSED;
                o_ctl.addr_sel  = fsat_pkg::A_SAVED;
            end
            fsat_pkg::S_FMT: begin
                o_ctl.emit     = 1'b1;
                o_ctl.cnt_inc  = 1'b1;
                o_ctl.cmd      = fsat_pkg::CMD_ERASE;
                o_ctl.addr_sel = fsat_pkg::A_HEADER;
            end
            fsat_pkg::S_SIG: begin
                o_ctl.emit        = 1'b1;
                o_ctl.last        = 1'b1;
                o_ctl.cache_clear = 1'b1;
                o_ctl.cmd         = fsat_pkg::CMD_SIGNATURE;
                o_ctl.addr_sel    = fsat_pkg::A_ZERO;
            end
            default: begin
                o_ctl.emit = 1'b0;
            end
        endcase
    end

    // pending phase and first-byte result
    always_comb begin
        n_phase    = r_phase;
        n_first_ok = r_first_ok;
        unique case (r_state)
            fsat_pkg::S_IDLE: begin
                if (w_accept && w_func != fsat_pkg::FUNC_FLAG) begin
                    n_phase = fsat_pkg::PH_IDLE;
                end
            end
            fsat_pkg::S_WCHECK: begin
                n_phase = i_sts.hit ? fsat_pkg::PH_IDLE : fsat_pkg::PH_WRITE;
            end
            fsat_pkg::S_RCHECK: begin
                if (i_sts.hit) begin
                    n_first_ok = 1'b1;
                end else begin
                    n_phase = fsat_pkg::PH_READ_FIRST;
                end
            end
            fsat_pkg::S_ECHECK: begin
                n_phase = i_sts.hit ? fsat_pkg::PH_IDLE : fsat_pkg::PH_READ_LAST;
            end
            fsat_pkg::S_RFREPLY: begin
                n_first_ok = !i_sts.flag_set;
            end
            fsat_pkg::S_WDATA, fsat_pkg::S_RLREPLY: begin
                n_phase = fsat_pkg::PH_IDLE;
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

endmodule

@@ design/fsat_dp.sv @@
// Datapath of the flash sector allocation tracker: saved request, ring cache
// of allocated sectors, header erase counter and result word register.
// Depends on fsat_pkg.
module fsat_dp #(
    parameter int SECTOR_BYTES   = fsat_pkg::SECTOR_BYTES_DEF,
    parameter int HEADER_SECTORS = fsat_pkg::HEADER_SECTORS_DEF,
    parameter int CACHE_ENTRIES  = fsat_pkg::CACHE_ENTRIES_DEF,
    parameter int ADDRESS_BITS   = fsat_pkg::ADDRESS_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  fsat_pkg::t_in   i_in,
    input  fsat_pkg::t_ctl  i_ctl,
    output fsat_pkg::t_sts  o_sts,
    output logic            o_valid,
    output fsat_pkg::t_out  o_out
);

    localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
    localparam int SEC_W  = (ADDRESS_BITS > SECTOR_SHIFT) ? ADDRESS_BITS - SECTOR_SHIFT : 1;
    localparam int PTR_W  = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int CNT_W  = (HEADER_SECTORS > 1) ? $clog2(HEADER_SECTORS) : 1;
    localparam logic [32:0] HDR_OFFSET = 33'(SECTOR_BYTES * HEADER_SECTORS);

    logic [ADDRESS_BITS-1:0] r_saddr;
    logic [15:0]             r_slen;
    logic [ADDRESS_BITS-1:0] r_end;
    logic [7:0]              r_fbyte;
    logic [SEC_W-1:0]        r_cache [CACHE_ENTRIES];
    logic [CACHE_ENTRIES-1:0] r_hit_vec;
    logic [PTR_W-1:0]        r_ptr;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_valid;
    fsat_pkg::t_out          r_out, n_out;

    logic [ADDRESS_BITS-1:0] w_key_addr;
    logic [31:0]             w_key_sec;
    logic [7:0]              w_mask;
    logic [31:0]             w_addr;

    assign w_key_addr = i_ctl.key_end ? r_end : r_saddr;
    assign w_key_sec  = 32'(w_key_addr) >> SECTOR_SHIFT;
    assign w_mask     = fsat_pkg::FLAG_BIT << w_key_sec[2:0];

    assign o_sts.hit      = |r_hit_vec;
    assign o_sts.flag_set = (r_fbyte & w_mask) != 8'd0;
    assign o_sts.cnt_done = (r_cnt == CNT_W'(HEADER_SECTORS - 1));

    // request registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_req) begin
            r_saddr <= ADDRESS_BITS'(33'(i_in.stream_address) + HDR_OFFSET);
            r_slen  <= i_in.byte_count;
        end
        if (i_ctl.load_item) begin
            r_fbyte <= i_in.flag_byte;
        end
        // a zero length wraps to start minus one
        r_end <= ADDRESS_BITS'(33'(r_saddr) + 33'(r_slen) - 33'd1);
    end

    // ring cache and lookup
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
            for (int i = 0; i < CACHE_ENTRIES; i++) begin
                r_cache[i] <= '0;
            end
        end else if (i_ctl.cache_clear) begin
            r_ptr <= '0;
            for (int i = 0; i < CACHE_ENTRIES; i++) begin
                r_cache[i] <= '0;
            end
        end else if (i_ctl.cache_add) begin
            r_cache[r_ptr] <= w_key_sec[SEC_W-1:0];
            r_ptr <= (r_ptr == PTR_W'(CACHE_ENTRIES - 1)) ? '0 : r_ptr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
            r_hit_vec[i] <= (r_cache[i] == w_key_sec[SEC_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_ctl.cnt_inc) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // result word
    always_comb begin
        unique case (i_ctl.addr_sel)
            fsat_pkg::A_SAVED:  w_addr = 32'(r_saddr);
            fsat_pkg::A_FLAG:   w_addr = (w_key_sec >> fsat_pkg::FLAG_BYTE_SHIFT)
                                         + fsat_pkg::SIGNATURE_BYTES;
            fsat_pkg::A_SECTOR: w_addr = w_key_sec << SECTOR_SHIFT;
            fsat_pkg::A_HEADER: w_addr = 32'(ADDRESS_BITS'(32'(r_cnt) << SECTOR_SHIFT));
            default:            w_addr = 32'd0;
        endcase
    end

    always_comb begin
        n_out               = '0;
        n_out.command       = i_ctl.cmd;
        n_out.flash_address = w_addr[25:0];
        n_out.last          = i_ctl.last;
        unique case (i_ctl.cmd)
            fsat_pkg::CMD_WRITE_DATA,
            fsat_pkg::CMD_READ_DATA:  n_out.data_length = r_slen;
            fsat_pkg::CMD_WRITE_FLAG: n_out.write_value = 32'(r_fbyte & ~w_mask);
            fsat_pkg::CMD_SIGNATURE:  n_out.write_value = fsat_pkg::SIGNATURE_WORD;
            default:                  n_out.data_length = 16'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctl.emit;
        end
        if (i_ctl.emit) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

endmodule

@@ dv/flash_sector_allocation_tracker_test.sv @@
// Self-checking test for flash_sector_allocation_tracker: directed words, then random
// request/reply sequences, checked against a cycle-free model of the allocation cache.
// Depends on fsat_pkg and the tracker RTL only.

class tracker_model;
    int unsigned      cache_sec[fsat_pkg::CACHE_ENTRIES_DEF];
    int unsigned      fill_slot;
    fsat_pkg::t_phase phase;
    logic [25:0]      req_addr;
    logic [15:0]      req_len;
    bit               first_ok;
    fsat_pkg::t_out   expected_cmds[$];
    int               errors;
    int               n_words;
    int               n_cmds;
    int               n_refused;
    int               n_erased;

    function new();
        foreach (cache_sec[i]) cache_sec[i] = 0;
        fill_slot = 0;
        phase     = fsat_pkg::PH_IDLE;
        req_addr  = '0;
        req_len   = '0;
        first_ok  = 1'b0;
        errors    = 0;
        n_words   = 0;
        n_cmds    = 0;
        n_refused = 0;
        n_erased  = 0;
    endfunction

    function bit cached(logic [25:0] a);
        int unsigned s;
        s = a / fsat_pkg::SECTOR_BYTES_DEF;
        foreach (cache_sec[i]) if (cache_sec[i] == s) return 1'b1;
        return 1'b0;
    endfunction

    function logic [25:0] flag_addr(logic [25:0] a);
        return 26'((a / fsat_pkg::SECTOR_BYTES_DEF) / (1 << fsat_pkg::FLAG_BYTE_SHIFT)
                   + fsat_pkg::SIGNATURE_BYTES);
    endfunction

    function logic [7:0] flag_bit(logic [25:0] a);
        return fsat_pkg::FLAG_BIT << ((a / fsat_pkg::SECTOR_BYTES_DEF)
                                      % (1 << fsat_pkg::FLAG_BYTE_SHIFT));
    endfunction

    function logic [25:0] end_addr();
        return req_addr + 26'(req_len) - 26'd1;
    endfunction

    // Bitmap bit that the next reply is judged on
    function logic [7:0] awaited_bit();
        return (phase == fsat_pkg::PH_READ_LAST) ? flag_bit(end_addr()) : flag_bit(req_addr);
    endfunction

    function void remember(logic [25:0] a);
        cache_sec[fill_slot] = a / fsat_pkg::SECTOR_BYTES_DEF;
        fill_slot = (fill_slot + 1) % fsat_pkg::CACHE_ENTRIES_DEF;
    endfunction

    function void push(fsat_pkg::t_cmd c, logic [25:0] a, logic [15:0] len, logic [31:0] v);
        fsat_pkg::t_out w;
        w.command       = c;
        w.flash_address = a;
        w.data_length   = len;
        w.write_value   = v;
        w.last          = 1'b0;
        expected_cmds.push_back(w);
        n_cmds++;
    endfunction

    function void close_read(bit ok);
        if (ok) begin
            push(fsat_pkg::CMD_READ_DATA, req_addr, req_len, '0);
        end else begin
            push(fsat_pkg::CMD_REFUSED, req_addr, '0, '0);
            n_refused++;
        end
        phase = fsat_pkg::PH_IDLE;
    endfunction

    function void check_tail();
        logic [25:0] e;
        e = end_addr();
        if (cached(e)) begin
            close_read(first_ok);
        end else begin
            push(fsat_pkg::CMD_READ_FLAG, flag_addr(e), '0, '0);
            phase = fsat_pkg::PH_READ_LAST;
        end
    endfunction

    function void note_word(fsat_pkg::t_in w);
        logic [25:0]    a;
        logic [7:0]     m;
        int             first;
        bit             ok;
        fsat_pkg::t_out tail;
        a = 26'(w.stream_address)
            + 26'(fsat_pkg::SECTOR_BYTES_DEF * fsat_pkg::HEADER_SECTORS_DEF);
        first = expected_cmds.size();
        n_words++;
        case (fsat_pkg::t_func'(w.func))
            fsat_pkg::FUNC_WRITE: begin
                phase    = fsat_pkg::PH_IDLE;
                req_addr = a;
                req_len  = w.byte_count;
                if (cached(a)) begin
                    push(fsat_pkg::CMD_WRITE_DATA, a, req_len, '0);
                end else begin
                    push(fsat_pkg::CMD_READ_FLAG, flag_addr(a), '0, '0);
                    phase = fsat_pkg::PH_WRITE;
                end
            end
            fsat_pkg::FUNC_READ: begin
                phase    = fsat_pkg::PH_IDLE;
                req_addr = a;
                req_len  = w.byte_count;
                if (cached(a)) begin
                    first_ok = 1'b1;
                    check_tail();
                end else begin
                    push(fsat_pkg::CMD_READ_FLAG, flag_addr(a), '0, '0);
                    phase = fsat_pkg::PH_READ_FIRST;
                end
            end
            fsat_pkg::FUNC_FLAG: begin
                case (phase)
                    fsat_pkg::PH_WRITE: begin
                        m = flag_bit(req_addr);
                        // Unallocated sector: erase it and clear its bit first
                        if ((w.flag_byte & m) != 0) begin
                            push(fsat_pkg::CMD_ERASE,
                                 26'((req_addr / fsat_pkg::SECTOR_BYTES_DEF)
                                     * fsat_pkg::SECTOR_BYTES_DEF),
                                 '0, '0);
                            push(fsat_pkg::CMD_WRITE_FLAG, flag_addr(req_addr), '0,
                                 32'(w.flag_byte & ~m));
                            n_erased++;
                        end
                        remember(req_addr);
                        push(fsat_pkg::CMD_WRITE_DATA, req_addr, req_len, '0);
                        phase = fsat_pkg::PH_IDLE;
                    end
                    fsat_pkg::PH_READ_FIRST: begin
                        ok = (w.flag_byte & flag_bit(req_addr)) == 0;
                        if (ok) remember(req_addr);
                        first_ok = ok;
                        check_tail();
                    end
                    fsat_pkg::PH_READ_LAST: begin
                        ok = (w.flag_byte & flag_bit(end_addr())) == 0;
                        if (ok) remember(end_addr());
                        close_read(ok && first_ok);
                    end
                    default: ;
                endcase
            end
            fsat_pkg::FUNC_FORMAT: begin
                phase = fsat_pkg::PH_IDLE;
                for (int i = 0; i < fsat_pkg::HEADER_SECTORS_DEF; i++)
                    push(fsat_pkg::CMD_ERASE, 26'(i * fsat_pkg::SECTOR_BYTES_DEF), '0, '0);
                push(fsat_pkg::CMD_SIGNATURE, '0, '0, fsat_pkg::SIGNATURE_WORD);
                foreach (cache_sec[i]) cache_sec[i] = 0;
                fill_slot = 0;
            end
        endcase
        if (expected_cmds.size() > first) begin
            tail = expected_cmds.pop_back();
            tail.last = 1'b1;
            expected_cmds.push_back(tail);
        end
    endfunction

    function void check_word(fsat_pkg::t_out got);
        fsat_pkg::t_out want;
        if (expected_cmds.size() == 0) begin
            errors++;
            $display("%0t: unexpected word: cmd %0d addr 0x%07h len %0d value 0x%08h last %0b",
                     $time, got.command, got.flash_address, got.data_length,
                     got.write_value, got.last);
            return;
        end
        want = expected_cmds.pop_front();
        if (got.command !== want.command || got.flash_address !== want.flash_address ||
            got.data_length !== want.data_length || got.write_value !== want.write_value ||
            got.last !== want.last) begin
            errors++;
            $display("%0t: mismatch: expected cmd %0d addr 0x%07h len %0d value 0x%08h last %0b,",
                     $time, want.command, want.flash_address, want.data_length,
                     want.write_value, want.last,
                     " got cmd %0d addr 0x%07h len %0d value 0x%08h last %0b",
                     got.command, got.flash_address, got.data_length,
                     got.write_value, got.last);
        end
    endfunction
endclass

module flash_sector_allocation_tracker_test;
    logic           i_clk   = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           start   = 1'b0;
    fsat_pkg::t_in  i_in    = '0;
    logic           busy;
    logic           o_valid;
    fsat_pkg::t_out o_out;

    tracker_model  tracker;
    bit            burst;
    int            counted;
    int            pick;
    fsat_pkg::t_in w;

    flash_sector_allocation_tracker DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_in    (i_in),
        .o_valid (o_valid),
        .o_out   (o_out)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) tracker.check_word(o_out);
    end

    // Hold the word until accepted, then idle for a drawn number of cycles
    task automatic send_word(input fsat_pkg::t_in word);
        int gap;
        @(negedge i_clk);
        start = 1'b1;
        i_in  = word;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        tracker.note_word(word);
        gap = burst ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            @(negedge i_clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic issue(fsat_pkg::t_func f, int unsigned saddr, int unsigned len,
                         int unsigned fb);
        fsat_pkg::t_in word;
        word.func           = f;
        word.stream_address = 25'(saddr);
        word.byte_count     = 16'(len);
        word.flag_byte      = 8'(fb);
        send_word(word);
    endtask

    // Mostly a dozen sectors so the cache both hits and misses
    function automatic fsat_pkg::t_in random_request(fsat_pkg::t_func f);
        fsat_pkg::t_in word;
        int            r;
        word.func = f;
        if ($urandom_range(0, 9) == 0)
            word.stream_address = 25'($urandom);
        else
            word.stream_address = 25'($urandom_range(0, 11) * fsat_pkg::SECTOR_BYTES_DEF +
                                      $urandom_range(0, fsat_pkg::SECTOR_BYTES_DEF - 1));
        r = $urandom_range(0, 9);
        if (r == 0)      word.byte_count = '0;
        else if (r == 1) word.byte_count = 16'hffff;
        else if (r == 2) word.byte_count = 16'($urandom);
        else             word.byte_count = 16'($urandom_range(1, 6000));
        word.flag_byte = 8'($urandom);
        return word;
    endfunction

    function automatic fsat_pkg::t_in flag_reply();
        fsat_pkg::t_in word;
        logic [7:0]    m;
        word.func           = fsat_pkg::FUNC_FLAG;
        word.stream_address = 25'($urandom);
        word.byte_count     = 16'($urandom);
        m = tracker.awaited_bit();
        word.flag_byte = 8'($urandom);
        if ($urandom_range(0, 99) < 60) word.flag_byte = word.flag_byte & ~m;
        else                            word.flag_byte = word.flag_byte | m;
        return word;
    endfunction

    initial begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        tracker = new();
        burst   = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        issue(fsat_pkg::FUNC_FORMAT, 0, 0, 0);
        // Miss on an unallocated sector: erase, flag write, data write
        issue(fsat_pkg::FUNC_WRITE, 0, 16, 0);
        issue(fsat_pkg::FUNC_FLAG, 0, 0, 8'hff);
        issue(fsat_pkg::FUNC_WRITE, 100, 0, 0);
        issue(fsat_pkg::FUNC_READ, 0, 1, 0);
        // Zero length read checks the header sector just below
        issue(fsat_pkg::FUNC_READ, 0, 0, 0);
        issue(fsat_pkg::FUNC_FLAG, 0, 0, 8'h00);
        // First byte cached, last byte in an unallocated sector
        issue(fsat_pkg::FUNC_READ, 4095, 2, 0);
        issue(fsat_pkg::FUNC_FLAG, 0, 0, 8'h10);
        issue(fsat_pkg::FUNC_READ, 33554431, 65535, 8'hff);
        issue(fsat_pkg::FUNC_FLAG, 33554431, 65535, 8'h00);
        issue(fsat_pkg::FUNC_FLAG, 0, 0, 8'hff);
        issue(fsat_pkg::FUNC_FLAG, 0, 0, 8'ha5);
        issue(fsat_pkg::FUNC_WRITE, 5 * 4096, 65535, 0);
        issue(fsat_pkg::FUNC_FLAG, 0, 0, 8'hfe);
        // Abandon a pending write with a new read
        issue(fsat_pkg::FUNC_WRITE, 6 * 4096, 8, 0);
        issue(fsat_pkg::FUNC_READ, 0, 1, 0);
        issue(fsat_pkg::FUNC_FLAG, 0, 0, 8'h00);
        issue(fsat_pkg::FUNC_READ, 7 * 4096 + 10, 100, 0);
        issue(fsat_pkg::FUNC_FLAG, 0, 0, 8'h04);
        issue(fsat_pkg::FUNC_FLAG, 0, 0, 8'h04);
        issue(fsat_pkg::FUNC_WRITE, 9 * 4096, 4, 0);
        issue(fsat_pkg::FUNC_FORMAT, 25'h1ffffff, 16'hffff, 8'hff);
        issue(fsat_pkg::FUNC_WRITE, 0, 16, 0);
        issue(fsat_pkg::FUNC_FLAG, 0, 0, 8'h00);

        counted = 0;
        while (counted < 500) begin
            if (counted % 40 == 0) burst = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (tracker.phase != fsat_pkg::PH_IDLE) begin
                if (pick < 85)      w = flag_reply();
                else if (pick < 97) w = random_request(pick[0] ? fsat_pkg::FUNC_READ
                                                               : fsat_pkg::FUNC_WRITE);
                else                w = random_request(fsat_pkg::FUNC_FORMAT);
                counted++;
            end else begin
                if (pick < 45)      w = random_request(fsat_pkg::FUNC_WRITE);
                else if (pick < 88) w = random_request(fsat_pkg::FUNC_READ);
                else if (pick < 95) w = flag_reply();
                else                w = random_request(fsat_pkg::FUNC_FORMAT);
                // A stray reply is dropped by the block and does not count
                if (pick < 88 || pick >= 95) counted++;
            end
            send_word(w);
        end
        @(negedge i_clk);
        start = 1'b0;

        while (tracker.expected_cmds.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Run covered %0d accepted words and %0d flash commands,",
                 tracker.n_words, tracker.n_cmds);
        $display("including %0d allocating erases and %0d refused reads; %0d errors.",
                 tracker.n_erased, tracker.n_refused, tracker.errors);
        if (tracker.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
design/fsat_pkg.sv
design/fsat_ctrl.sv
design/fsat_dp.sv
design/flash_sector_allocation_tracker.sv
dv/flash_sector_allocation_tracker_test.sv
